@@ rtl/jtl_pkg.sv @@
// jtl_pkg: shared types, codes and keyword tables of the json token lexer
// no dependencies; imported by every module under rtl
`default_nettype none
package jtl_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_TRUE     = 4'd8;
  localparam logic [3:0] KIND_FALSE    = 4'd9;
  localparam logic [3:0] KIND_NULL     = 4'd10;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_INVALID   = 3'd1;
  localparam logic [2:0] ERR_KEYWORD   = 3'd2;
  localparam logic [2:0] ERR_UNTERM    = 3'd3;
  localparam logic [2:0] ERR_NONASCII  = 3'd4;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_KEYWORD = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_NUMBER  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CLS_PUNCT = 3'd0,
    CLS_WS    = 3'd1,
    CLS_KW    = 3'd2,
    CLS_QUOTE = 3'd3,
    CLS_DIGIT = 3'd4,
    CLS_DOT   = 3'd5,
    CLS_OTHER = 3'd6
  } cls_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       eot;
    cls_t       cls;
    logic [3:0] punct_kind;
    logic [1:0] kw_id;
  } item_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] byte_val;
    logic       first;
    logic       last;
    logic [2:0] err;
  } result_t;

  function automatic logic [2:0] kw_len(input logic [1:0] id);
    case (id)
      KW_TRUE:  kw_len = 3'd4;
      KW_FALSE: kw_len = 3'd5;
      KW_NULL:  kw_len = 3'd4;
      default:  kw_len = 3'd0;
    endcase
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] id);
    case (id)
      KW_TRUE:  kw_kind = KIND_TRUE;
      KW_FALSE: kw_kind = KIND_FALSE;
      KW_NULL:  kw_kind = KIND_NULL;
      default:  kw_kind = KIND_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
    case ({id, pos})
      {KW_TRUE, 3'd0}:  kw_char = "t";
      {KW_TRUE, 3'd1}:  kw_char = "r";
      {KW_TRUE, 3'd2}:  kw_char = "u";
      {KW_TRUE, 3'd3}:  kw_char = "e";
      {KW_FALSE, 3'd0}: kw_char = "f";
      {KW_FALSE, 3'd1}: kw_char = "a";
      {KW_FALSE, 3'd2}: kw_char = "l";
      {KW_FALSE, 3'd3}: kw_char = "s";
      {KW_FALSE, 3'd4}: kw_char = "e";
      {KW_NULL, 3'd0}:  kw_char = "n";
      {KW_NULL, 3'd1}:  kw_char = "u";
      {KW_NULL, 3'd2}:  kw_char = "l";
      {KW_NULL, 3'd3}:  kw_char = "l";
      default:          kw_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/jtl_front.sv @@
// jtl_front: accepts input beats and classifies each byte for the back end
// depends on jtl_pkg; feeds jtl_queue
`default_nettype none
module jtl_front (
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // in_byte
  input  wire logic          in_tlast,   // end_of_text
  input  wire logic          q_full,
  output logic               q_push,
  output jtl_pkg::item_t     q_item
);
  import jtl_pkg::*;

  cls_t       cls;
  logic [3:0] pkind;
  logic [1:0] kid;

  always_comb begin
    cls   = CLS_OTHER;
    pkind = KIND_LBRACE;
    kid   = KW_TRUE;
    case (in_tdata)
      "{": begin cls = CLS_PUNCT; pkind = KIND_LBRACE; end
      "}": begin cls = CLS_PUNCT; pkind = KIND_RBRACE; end
      "[": begin cls = CLS_PUNCT; pkind = KIND_LBRACKET; end
      "]": begin cls = CLS_PUNCT; pkind = KIND_RBRACKET; end
      ":": begin cls = CLS_PUNCT; pkind = KIND_COLON; end
      ",": begin cls = CLS_PUNCT; pkind = KIND_COMMA; end
      8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: cls = CLS_WS;
      "t": begin cls = CLS_KW; kid = KW_TRUE; end
      "f": begin cls = CLS_KW; kid = KW_FALSE; end
      "n": begin cls = CLS_KW; kid = KW_NULL; end
      CH_QUOTE: cls = CLS_QUOTE;
      CH_DOT:   cls = CLS_DOT;
      default: begin
        if (in_tdata >= "0" && in_tdata <= "9") cls = CLS_DIGIT;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.byte_val   = in_tdata;
    q_item.eot        = in_tlast;
    q_item.cls        = cls;
    q_item.punct_kind = pkind;
    q_item.kw_id      = kid;
  end

endmodule
`default_nettype wire

@@ rtl/jtl_queue.sv @@
// jtl_queue: short flop queue of classified bytes between front and back end
// depends on jtl_pkg
`default_nettype none
module jtl_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire jtl_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output jtl_pkg::item_t      head
);
  import jtl_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]      cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/jtl_back.sv @@
// jtl_back: lexer state machine, result register and second-result slot
// depends on jtl_pkg; drains jtl_queue
`default_nettype none
module jtl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  wire jtl_pkg::item_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output jtl_pkg::result_t    out_res
);
  import jtl_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [1:0] kw_id_r, kw_id_nxt;
  logic [2:0] kw_pos_r, kw_pos_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_first_r, held_first_nxt;
  logic       err_r, err_nxt;

  logic       out_valid_r;
  result_t    out_res_r;
  logic       pend_valid_r;
  result_t    pend_res_r;

  // idle handling of the head byte
  logic       idle_v;
  result_t    idle_res;
  mode_t      idle_mode;
  logic       idle_err;
  logic       idle_kw;
  logic       idle_num;

  // step results
  logic       r0_v, r1_v;
  result_t    r0, r1;

  logic [7:0] b;
  logic       eot;
  logic       can_load;
  logic       step;
  logic [2:0] pos_inc;

  assign b        = q_head.byte_val;
  assign eot      = q_head.eot;
  assign can_load = !out_valid_r || out_ready;
  assign step     = can_load && !pend_valid_r && q_not_empty;
  assign q_pop    = step;
  assign pos_inc  = kw_pos_r + 3'd1;

  always_comb begin
    idle_v    = 1'b0;
    idle_res  = '{kind: KIND_LBRACE, byte_val: b, first: 1'b0, last: 1'b0, err: ERR_NONE};
    idle_mode = MODE_IDLE;
    idle_err  = 1'b0;
    idle_kw   = 1'b0;
    idle_num  = 1'b0;
    case (q_head.cls)
      CLS_PUNCT: begin
        idle_v   = 1'b1;
        idle_res = '{kind: q_head.punct_kind, byte_val: b, first: 1'b1, last: 1'b1,
                     err: ERR_NONE};
      end
      CLS_WS: idle_v = 1'b0;
      CLS_KW: begin
        if (eot) begin
          idle_v = 1'b1; idle_err = 1'b1; idle_res.err = ERR_KEYWORD;
        end else begin
          idle_kw = 1'b1; idle_mode = MODE_KEYWORD;
        end
      end
      CLS_QUOTE: begin
        idle_v = 1'b1;
        if (eot) begin
          idle_err = 1'b1; idle_res.err = ERR_UNTERM;
        end else begin
          idle_mode = MODE_STRING;
          idle_res  = '{kind: KIND_STRING, byte_val: b, first: 1'b1, last: 1'b0,
                        err: ERR_NONE};
        end
      end
      CLS_DIGIT: begin
        if (eot) begin
          idle_v   = 1'b1;
          idle_res = '{kind: KIND_NUMBER, byte_val: b, first: 1'b1, last: 1'b1,
                       err: ERR_NONE};
        end else begin
          idle_num = 1'b1; idle_mode = MODE_NUMBER;
        end
      end
      default: begin
        idle_v = 1'b1; idle_err = 1'b1; idle_res.err = ERR_INVALID;
      end
    endcase
  end

  always_comb begin
    mode_nxt       = mode_r;
    kw_id_nxt      = kw_id_r;
    kw_pos_nxt     = kw_pos_r;
    held_nxt       = held_r;
    held_first_nxt = held_first_r;
    err_nxt        = err_r;
    r0_v = 1'b0;
    r1_v = 1'b0;
    r0   = '{kind: KIND_LBRACE, byte_val: b, first: 1'b0, last: 1'b0, err: ERR_NONE};
    r1   = r0;
    if (!err_r) begin
      case (mode_r)
        MODE_IDLE: begin
          r0_v     = idle_v;
          r0       = idle_res;
          mode_nxt = idle_mode;
          err_nxt  = idle_err;
          if (idle_kw) begin
            kw_id_nxt = q_head.kw_id; kw_pos_nxt = 3'd1;
          end
          if (idle_err) kw_pos_nxt = 3'd0;
          if (idle_num) begin
            held_nxt = b; held_first_nxt = 1'b1;
          end
        end
        MODE_KEYWORD: begin
          r0_v = 1'b1;
          if (kw_pos_r < kw_len(kw_id_r) && b == kw_char(kw_id_r, kw_pos_r)) begin
            if (pos_inc == kw_len(kw_id_r)) begin
              mode_nxt   = MODE_IDLE;
              kw_pos_nxt = 3'd0;
              r0 = '{kind: kw_kind(kw_id_r), byte_val: b, first: 1'b1, last: 1'b1,
                     err: ERR_NONE};
            end else if (eot) begin
              mode_nxt = MODE_IDLE; kw_pos_nxt = 3'd0; err_nxt = 1'b1;
              r0.err   = ERR_KEYWORD;
            end else begin
              r0_v       = 1'b0;
              kw_pos_nxt = pos_inc;
            end
          end else begin
            mode_nxt = MODE_IDLE; kw_pos_nxt = 3'd0; err_nxt = 1'b1;
            r0.err   = ERR_KEYWORD;
          end
        end
        MODE_STRING: begin
          r0_v = 1'b1;
          if (b == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            r0 = '{kind: KIND_STRING, byte_val: b, first: 1'b0, last: 1'b1, err: ERR_NONE};
          end else if (b[7]) begin
            mode_nxt = MODE_IDLE; kw_pos_nxt = 3'd0; err_nxt = 1'b1;
            r0.err   = ERR_NONASCII;
          end else begin
            r0 = '{kind: KIND_STRING, byte_val: b, first: 1'b0, last: 1'b0, err: ERR_NONE};
            if (eot) begin
              r1_v     = 1'b1;
              r1.err   = ERR_UNTERM;
              mode_nxt = MODE_IDLE; kw_pos_nxt = 3'd0; err_nxt = 1'b1;
            end
          end
        end
        default: begin
          r0_v = 1'b1;
          if (q_head.cls == CLS_DIGIT || q_head.cls == CLS_DOT) begin
            r0 = '{kind: KIND_NUMBER, byte_val: held_r, first: held_first_r, last: 1'b0,
                   err: ERR_NONE};
            held_first_nxt = 1'b0;
            if (eot) begin
              mode_nxt = MODE_IDLE;
              r1_v     = 1'b1;
              r1 = '{kind: KIND_NUMBER, byte_val: b, first: 1'b0, last: 1'b1, err: ERR_NONE};
            end else begin
              held_nxt = b;
            end
          end else begin
            r0 = '{kind: KIND_NUMBER, byte_val: held_r, first: held_first_r, last: 1'b1,
                   err: ERR_NONE};
            held_first_nxt = 1'b0;
            r1_v     = idle_v;
            r1       = idle_res;
            mode_nxt = idle_mode;
            err_nxt  = idle_err;
            if (idle_kw) begin
              kw_id_nxt = q_head.kw_id; kw_pos_nxt = 3'd1;
            end
            if (idle_err) kw_pos_nxt = 3'd0;
            if (idle_num) begin
              held_nxt = b; held_first_nxt = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      kw_id_r      <= '0;
      kw_pos_r     <= '0;
      held_r       <= '0;
      held_first_r <= 1'b0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (step) begin
        mode_r       <= mode_nxt;
        kw_id_r      <= kw_id_nxt;
        kw_pos_r     <= kw_pos_nxt;
        held_r       <= held_nxt;
        held_first_r <= held_first_nxt;
        err_r        <= err_nxt;
      end
      if (can_load) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= 1'b0;
        end else if (step) begin
          out_valid_r  <= r0_v || r1_v;
          pend_valid_r <= r0_v && r1_v;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_valid_r) begin
        out_res_r <= pend_res_r;
      end else if (step) begin
        out_res_r  <= r0_v ? r0 : r1;
        pend_res_r <= r1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

@@ rtl/json_token_lexer.sv @@
// json_token_lexer: byte-serial json tokenizer, top level
// depends on jtl_pkg, jtl_front, jtl_queue and jtl_back
//
//  channel  dir  tdata            tuser                        tlast
//  in_      in   in_byte[7:0]     -                            end_of_text
//  out_     out  value_byte[7:0]  kind[3:0] first[4] err[7:5]  token_last
//
// one byte per cycle sustained while the output is ready; a byte giving two tokens holds
// the back end while its second result goes out
// an input beat is registered in the queue, then its result in the result register
// synchronous active-low reset clears lexer state, queue pointers and output valid flags
// a 4-entry queue lets the front keep accepting while the output stalls, until it fills
`default_nettype none
module json_token_lexer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // in_byte
  input  wire logic       in_tlast,   // end_of_text
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // value_byte
  output logic [7:0]      out_tuser,  // token_kind[3:0], token_first[4], error_code[7:5]
  output logic            out_tlast   // token_last
);
  import jtl_pkg::*;

  logic    q_full, q_push, q_pop, q_not_empty;
  item_t   q_in, q_head;
  result_t res;

  jtl_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  jtl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  jtl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = res.byte_val;
  assign out_tuser = {res.err, res.first, res.kind};
  assign out_tlast = res.last;

endmodule
`default_nettype wire

@@ verif/json_token_lexer_checker.sv @@
// json_token_lexer_checker: watches the input and token channels of the lexer,
// predicts the token beats of every accepted input beat and compares them in order
// depends on jtl_pkg for the token kinds, error codes, mode enum and result layout
module json_token_lexer_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [7:0] out_tuser,
  input  logic       out_tlast,
  input  logic       final_check,
  output int         fail_count,
  output int         pending,
  output int         tokens_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import jtl_pkg::*;

  localparam logic [3:0] ERR_KIND = 4'd0;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam int         MAX_PRINTS = 40;

  mode_t      lex_mode;
  logic [1:0] kw_sel;
  logic [2:0] kw_pos;
  logic [7:0] held_char;
  logic       held_first;
  logic       stuck;
  result_t    token_q[$];

  function automatic logic [2:0] keyword_length(input logic [1:0] id);
    return (id == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] keyword_letter(input logic [1:0] id, input logic [2:0] pos);
    logic [39:0] txt;
    case (id)
      KW_TRUE:  txt = {"true", 8'h00};
      KW_FALSE: txt = "false";
      default:  txt = {"null", 8'h00};
    endcase
    return txt[8 * (4 - pos) +: 8];
  endfunction

  function automatic logic [3:0] keyword_kind(input logic [1:0] id);
    case (id)
      KW_TRUE:  return KIND_TRUE;
      KW_FALSE: return KIND_FALSE;
      default:  return KIND_NULL;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic report(input string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic add_token(input logic [3:0] kind, input logic [7:0] b, input logic first,
                           input logic last, input logic [2:0] err);
    result_t r;
    r.kind     = kind;
    r.byte_val = b;
    r.first    = first;
    r.last     = last;
    r.err      = err;
    token_q.push_back(r);
  endtask

  task automatic lex_fail(input logic [2:0] code, input logic [7:0] b);
    stuck    = 1'b1;
    lex_mode = MODE_IDLE;
    kw_pos   = 3'd0;
    add_token(ERR_KIND, b, 1'b0, 1'b0, code);
  endtask

  task automatic idle_char(input logic [7:0] b, input logic eot);
    case (b)
      "{": add_token(KIND_LBRACE, b, 1'b1, 1'b1, ERR_NONE);
      "}": add_token(KIND_RBRACE, b, 1'b1, 1'b1, ERR_NONE);
      "[": add_token(KIND_LBRACKET, b, 1'b1, 1'b1, ERR_NONE);
      "]": add_token(KIND_RBRACKET, b, 1'b1, 1'b1, ERR_NONE);
      ":": add_token(KIND_COLON, b, 1'b1, 1'b1, ERR_NONE);
      ",": add_token(KIND_COMMA, b, 1'b1, 1'b1, ERR_NONE);
      " ", CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ;
      "t", "f", "n": begin
        if (eot) begin
          lex_fail(ERR_KEYWORD, b);
        end else begin
          kw_sel   = (b == "t") ? KW_TRUE : ((b == "f") ? KW_FALSE : KW_NULL);
          kw_pos   = 3'd1;
          lex_mode = MODE_KEYWORD;
        end
      end
      CH_QUOTE: begin
        if (eot) begin
          lex_fail(ERR_UNTERM, b);
        end else begin
          lex_mode = MODE_STRING;
          add_token(KIND_STRING, b, 1'b1, 1'b0, ERR_NONE);
        end
      end
      default: begin
        if (!is_digit(b)) begin
          lex_fail(ERR_INVALID, b);
        end else if (eot) begin
          add_token(KIND_NUMBER, b, 1'b1, 1'b1, ERR_NONE);
        end else begin
          held_char  = b;
          held_first = 1'b1;
          lex_mode   = MODE_NUMBER;
        end
      end
    endcase
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic eot);
    logic [2:0] pos;
    if (stuck) return;
    case (lex_mode)
      MODE_IDLE: idle_char(b, eot);
      MODE_KEYWORD: begin
        pos = kw_pos;
        if (pos < keyword_length(kw_sel) && b == keyword_letter(kw_sel, pos)) begin
          pos = pos + 3'd1;
          if (pos == keyword_length(kw_sel)) begin
            lex_mode = MODE_IDLE;
            kw_pos   = 3'd0;
            add_token(keyword_kind(kw_sel), b, 1'b1, 1'b1, ERR_NONE);
          end else if (eot) begin
            lex_fail(ERR_KEYWORD, b);
          end else begin
            kw_pos = pos;
          end
        end else begin
          lex_fail(ERR_KEYWORD, b);
        end
      end
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          lex_mode = MODE_IDLE;
          add_token(KIND_STRING, b, 1'b0, 1'b1, ERR_NONE);
        end else if (b[7]) begin
          lex_fail(ERR_NONASCII, b);
        end else begin
          add_token(KIND_STRING, b, 1'b0, 1'b0, ERR_NONE);
          if (eot) lex_fail(ERR_UNTERM, b);
        end
      end
      default: begin
        if (is_digit(b) || b == CH_DOT) begin
          add_token(KIND_NUMBER, held_char, held_first, 1'b0, ERR_NONE);
          held_first = 1'b0;
          if (eot) begin
            lex_mode = MODE_IDLE;
            add_token(KIND_NUMBER, b, 1'b0, 1'b1, ERR_NONE);
          end else begin
            held_char = b;
          end
        end else begin
          add_token(KIND_NUMBER, held_char, held_first, 1'b1, ERR_NONE);
          lex_mode   = MODE_IDLE;
          held_first = 1'b0;
          idle_char(b, eot);
        end
      end
    endcase
  endtask

  task automatic check_beat();
    result_t want;
    if (token_q.size() == 0) begin
      report($sformatf("token beat with nothing expected: data %02h user %02h last %0b",
                       out_tdata, out_tuser, out_tlast));
      return;
    end
    want = token_q.pop_front();
    tokens_checked++;
    if (out_tuser[3:0] !== want.kind)
      report($sformatf("beat %0d kind %0d, want %0d", tokens_checked, out_tuser[3:0], want.kind));
    if (out_tdata !== want.byte_val)
      report($sformatf("beat %0d byte %02h, want %02h", tokens_checked, out_tdata,
                       want.byte_val));
    if (out_tuser[4] !== want.first)
      report($sformatf("beat %0d first %0b, want %0b", tokens_checked, out_tuser[4],
                       want.first));
    if (out_tlast !== want.last)
      report($sformatf("beat %0d last %0b, want %0b", tokens_checked, out_tlast, want.last));
    if (out_tuser[7:5] !== want.err)
      report($sformatf("beat %0d error %0d, want %0d", tokens_checked, out_tuser[7:5],
                       want.err));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_mode       = MODE_IDLE;
      kw_sel         = KW_TRUE;
      kw_pos         = 3'd0;
      held_char      = 8'h00;
      held_first     = 1'b0;
      stuck          = 1'b0;
      token_q.delete();
      fail_count     = 0;
      tokens_checked = 0;
      pending       <= 0;
    end else begin
      if (in_tvalid && in_tready) lex_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_beat();
      if (final_check) begin
        while (token_q.size() > 0) begin
          report($sformatf("expected token never came: kind %0d byte %02h",
                           token_q[0].kind, token_q[0].byte_val));
          void'(token_q.pop_front());
        end
      end
      pending <= token_q.size();
    end
  end

endmodule

@@ verif/json_token_lexer_tb.sv @@
// json_token_lexer_tb: drives json text into the lexer with random gaps and output
// stalls, then gives the verdict from the checker's failure count
// depends on jtl_pkg, json_token_lexer and json_token_lexer_checker
module json_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jtl_pkg::*;

  localparam logic [47:0] PUNCT_CHARS = "{}[]:,";
  localparam logic [47:0] WS_CHARS    = {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  localparam int          RANDOM_ITEMS = 340;
  localparam int          LONG_HOLD    = 300;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       final_check = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [7:0] out_tuser;
  logic       out_tlast;

  int    fail_count;
  int    pending;
  int    tokens_checked;
  int    sent_count = 0;
  int    burst_left = 0;
  int    stall_left = 0;
  int    run_left   = 0;
  int    rx_pick;
  bit    long_hold_done = 1'b0;
  string tail_case;

  json_token_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  json_token_lexer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .final_check    (final_check),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_checked (tokens_checked)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("** json_token_lexer: FAILED **");
    $finish;
  end

  // token side: random stalls, full-speed stretches and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!long_hold_done && sent_count >= 150) begin
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (run_left > 0) begin
      out_tready <= 1'b1;
      run_left--;
    end else begin
      rx_pick = $urandom_range(0, 9);
      if (rx_pick < 5) begin
        run_left = $urandom_range(1, 30);
        out_tready <= 1'b1;
      end else if (rx_pick < 9) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        stall_left = $urandom_range(9, 39);
        out_tready <= 1'b0;
      end
    end
  end

  function automatic string keyword_word(input int id);
    case (id)
      0:       return "true";
      1:       return "false";
      default: return "null";
    endcase
  endfunction

  function automatic bit lexable(input logic [7:0] b);
    int i;
    for (i = 0; i < 6; i++) begin
      if (b == PUNCT_CHARS[8 * i +: 8] || b == WS_CHARS[8 * i +: 8]) return 1'b1;
    end
    return (b >= "0" && b <= "9") || b == "t" || b == "f" || b == "n" || b == CH_QUOTE;
  endfunction

  function automatic logic [7:0] string_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 127)); while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic logic end_flag();
    return $urandom_range(0, 7) == 0;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eot);
    int pick;
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) burst_left = $urandom_range(10, 40);
      else if (pick < 9) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s, input bit eot_last);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(s[i], eot_last && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_token();
    int    pick;
    int    n;
    int    i;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_beat(PUNCT_CHARS[8 * $urandom_range(0, 5) +: 8], end_flag());
    end else if (pick < 45) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++)
        send_beat(WS_CHARS[8 * $urandom_range(0, 5) +: 8], i == n - 1 && end_flag());
    end else if (pick < 60) begin
      send_text(keyword_word($urandom_range(0, 2)), end_flag());
    end else if (pick < 80) begin
      send_beat(CH_QUOTE, 1'b0);
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) send_beat(string_char(), 1'b0);
      send_beat(CH_QUOTE, end_flag());
    end else begin
      n = $urandom_range(0, 5);
      send_beat(8'("0" + $urandom_range(0, 9)), n == 0 && end_flag());
      for (i = 0; i < n; i++) begin
        send_beat(($urandom_range(0, 3) == 0) ? CH_DOT : 8'("0" + $urandom_range(0, 9)),
                  i == n - 1 && end_flag());
      end
    end
  endtask

  // a sticky error ends the useful part of the run, so one error case closes it
  task automatic send_error_tail();
    int         n;
    int         i;
    string      w;
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: begin
        tail_case = "invalid character";
        do b = 8'($urandom_range(0, 255)); while (lexable(b));
        send_beat(b, 1'($urandom_range(0, 1)));
      end
      1: begin
        tail_case = "keyword mismatch";
        w = keyword_word($urandom_range(0, 2));
        n = $urandom_range(1, w.len() - 1);
        for (i = 0; i < n; i++) send_beat(w[i], 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b == w[n]);
        send_beat(b, 1'($urandom_range(0, 1)));
      end
      2: begin
        tail_case = "keyword cut off";
        w = keyword_word($urandom_range(0, 2));
        n = $urandom_range(1, w.len() - 1);
        for (i = 0; i < n; i++) send_beat(w[i], i == n - 1);
      end
      3: begin
        tail_case = "non-ascii byte in string";
        send_beat(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) send_beat(string_char(), 1'b0);
        send_beat(8'($urandom_range(128, 255)), 1'($urandom_range(0, 1)));
      end
      default: begin
        tail_case = "string cut off";
        n = $urandom_range(0, 3);
        send_beat(CH_QUOTE, n == 0);
        for (i = 0; i < n; i++) send_beat(string_char(), i == n - 1);
      end
    endcase
    repeat (24) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every token kind, string byte extremes, number flush on end of text
    send_text("{\"", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h7f, 1'b0);
    send_text("\":[true,false,null,0.9]}", 1'b1);
    send_beat("5", 1'b1);
    wait_drained();

    while (sent_count < 30 + RANDOM_ITEMS) send_token();
    send_beat(" ", 1'b0);
    wait_drained();

    send_error_tail();
    wait_drained();
    repeat (16) @(posedge clk);
    final_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("covered %0d input beats and %0d token beats, all token kinds and whitespace,",
             sent_count, tokens_checked);
    $display("with a %0d-cycle output hold-off; run closed on a %s and ignored bytes after it",
             LONG_HOLD, tail_case);
    if (fail_count == 0) begin
      $display("** json_token_lexer: PASSED **");
    end else begin
      $display("** json_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule

@@ json_token_lexer.f @@
rtl/jtl_pkg.sv
rtl/jtl_front.sv
rtl/jtl_queue.sv
rtl/jtl_back.sv
rtl/json_token_lexer.sv
verif/json_token_lexer_checker.sv
verif/json_token_lexer_tb.sv
